### design/aoc_pkg.sv
package aoc_pkg;

    localparam int CH_W      = 8;    // color channel width
    localparam int ALPHA_W   = 7;    // alpha in percent
    localparam int W_W       = 14;   // weights, up to 100*100
    localparam int NUM_W     = 22;   // numerator, up to 255*10000, and the partial remainder
    localparam int QUO_W     = 8;    // quotient bits, one per divider stage
    localparam int N_CH      = 3;    // red, green, blue
    localparam int PROD_W    = 26;   // total * reciprocal of 100
    localparam int RECIP_W   = 13;
    localparam int RECIP_SH  = 19;   // floor(x*5243 >> 19) == x/100 for x < 43699

    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 7'd100;
    localparam logic [RECIP_W-1:0] RECIP_100  = 13'd5243;

    localparam int DIV_SHIFT = QUO_W - 1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [N_CH-1:0][NUM_W-1:0] rem;
        logic [N_CH-1:0][QUO_W-1:0] quo;
        logic [W_W-1:0]             divisor;
        logic [ALPHA_W-1:0]         alpha;
    } aoc_div_t;

endpackage

### design/aoc_weight.sv
module aoc_weight (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [aoc_pkg::CH_W-1:0]    back_red,
    input  logic [aoc_pkg::CH_W-1:0]    back_green,
    input  logic [aoc_pkg::CH_W-1:0]    back_blue,
    input  logic [aoc_pkg::ALPHA_W-1:0] back_alpha,
    input  logic [aoc_pkg::CH_W-1:0]    top_red,
    input  logic [aoc_pkg::CH_W-1:0]    top_green,
    input  logic [aoc_pkg::CH_W-1:0]    top_blue,
    input  logic [aoc_pkg::ALPHA_W-1:0] top_alpha,
    output logic                      out_valid,
    input  logic                      out_ready,
    output aoc_pkg::aoc_div_t         out_data
);
    import aoc_pkg::*;

    logic [ALPHA_W-1:0] a_sat;
    logic [ALPHA_W-1:0] pa_sat;
    logic               rdy1;
    logic               rdy2;
    logic               rdy3;

    // stage 1: saturated alphas and the two weights
    logic                       v1_reg;
    logic [N_CH-1:0][CH_W-1:0]  top1_reg;
    logic [N_CH-1:0][CH_W-1:0]  back1_reg;
    logic [W_W-1:0]             wtop1_reg;
    logic [W_W-1:0]             wback1_reg;

    // stage 2: per-channel products and the combined weight
    logic                       v2_reg;
    logic [N_CH-1:0][NUM_W-1:0] ptop2_reg;
    logic [N_CH-1:0][NUM_W-1:0] pback2_reg;
    logic [W_W-1:0]             total2_reg;

    // stage 3: numerators and scaled total for the alpha
    logic                       v3_reg;
    logic [N_CH-1:0][NUM_W-1:0] num3_reg;
    logic [W_W-1:0]             total3_reg;
    logic [PROD_W-1:0]          aprod3_reg;

    assign a_sat  = (back_alpha > ALPHA_FULL) ? ALPHA_FULL : back_alpha;
    assign pa_sat = (top_alpha > ALPHA_FULL) ? ALPHA_FULL : top_alpha;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            top1_reg[CH_RED]    <= top_red;
            top1_reg[CH_GREEN]  <= top_green;
            top1_reg[CH_BLUE]   <= top_blue;
            back1_reg[CH_RED]   <= back_red;
            back1_reg[CH_GREEN] <= back_green;
            back1_reg[CH_BLUE]  <= back_blue;
            wtop1_reg  <= W_W'(pa_sat) * W_W'(ALPHA_FULL);
            wback1_reg <= W_W'(a_sat) * W_W'(ALPHA_FULL - pa_sat);
        end
        if (rdy2 && v1_reg)
        begin
            for (int c = 0; c < N_CH; c++)
            begin
                ptop2_reg[c]  <= NUM_W'(top1_reg[c]) * NUM_W'(wtop1_reg);
                pback2_reg[c] <= NUM_W'(back1_reg[c]) * NUM_W'(wback1_reg);
            end
            total2_reg <= wtop1_reg + wback1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            for (int c = 0; c < N_CH; c++)
                num3_reg[c] <= ptop2_reg[c] + pback2_reg[c];
            total3_reg <= total2_reg;
            aprod3_reg <= PROD_W'(total2_reg) * PROD_W'(RECIP_100);
        end
    end

    assign out_valid        = v3_reg;
    assign out_data.rem     = num3_reg;
    assign out_data.quo     = '0;
    assign out_data.divisor = total3_reg;
    assign out_data.alpha   = aprod3_reg[RECIP_SH +: ALPHA_W];

endmodule

### design/aoc_div_stage.sv
module aoc_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aoc_pkg::aoc_div_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aoc_pkg::aoc_div_t out_data
);
    import aoc_pkg::*;

    logic              valid_reg;
    aoc_div_t          data_reg;
    aoc_div_t          data_next;
    logic [NUM_W-1:0]  dvs_aligned;
    logic [NUM_W-1:0]  rem_sub;
    logic [N_CH-1:0]   ge;

    // Restoring step on a left-shifting remainder: the divisor stays aligned at
    // the top quotient bit, and rem < 2*dvs_aligned holds on entry since the
    // numerator is at most 255 times the divisor.
    assign dvs_aligned = NUM_W'(in_data.divisor) << DIV_SHIFT;

    always_comb
    begin
        data_next = in_data;
        rem_sub   = '0;
        for (int c = 0; c < N_CH; c++)
        begin
            ge[c]   = in_data.rem[c] >= dvs_aligned;
            rem_sub = ge[c] ? (in_data.rem[c] - dvs_aligned) : in_data.rem[c];
            data_next.rem[c] = {rem_sub[NUM_W-2:0], 1'b0};
            data_next.quo[c] = {in_data.quo[c][QUO_W-2:0], ge[c]};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/alpha_over_composite_percent_top.sv
// Source-over composite of a pasted pixel onto a background pixel, alphas in
// percent (inputs above 100 count as 100). One item per clock while the output is
// not stalled. Three stages form the weights, products and
// numerators, then eight identical restoring-division stages each produce one
// quotient bit for all three colors in parallel. Output alpha is the combined
// weight divided by 100 through a reciprocal multiply. Colors are 0 when both
// alphas are 0. Every stage holds its item under backpressure and bubbles are
// squeezed out, so a stalled output does not stop intake while stages are empty.
module alpha_over_composite_percent_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [aoc_pkg::CH_W-1:0]    back_red,
    input  logic [aoc_pkg::CH_W-1:0]    back_green,
    input  logic [aoc_pkg::CH_W-1:0]    back_blue,
    input  logic [aoc_pkg::ALPHA_W-1:0] back_alpha,
    input  logic [aoc_pkg::CH_W-1:0]    top_red,
    input  logic [aoc_pkg::CH_W-1:0]    top_green,
    input  logic [aoc_pkg::CH_W-1:0]    top_blue,
    input  logic [aoc_pkg::ALPHA_W-1:0] top_alpha,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [aoc_pkg::CH_W-1:0]    out_red,
    output logic [aoc_pkg::CH_W-1:0]    out_green,
    output logic [aoc_pkg::CH_W-1:0]    out_blue,
    output logic [aoc_pkg::ALPHA_W-1:0] out_alpha
);
    import aoc_pkg::*;

    logic     [QUO_W:0] v;
    logic     [QUO_W:0] rdy;
    aoc_div_t           d [QUO_W+1];
    logic               zero_w;

    aoc_weight u_weight (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .back_red   (back_red),
        .back_green (back_green),
        .back_blue  (back_blue),
        .back_alpha (back_alpha),
        .top_red    (top_red),
        .top_green  (top_green),
        .top_blue   (top_blue),
        .top_alpha  (top_alpha),
        .out_valid  (v[0]),
        .out_ready  (rdy[0]),
        .out_data   (d[0])
    );

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        aoc_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[i]),
            .in_ready  (rdy[i]),
            .in_data   (d[i]),
            .out_valid (v[i+1]),
            .out_ready (rdy[i+1]),
            .out_data  (d[i+1])
        );
    end

    assign rdy[QUO_W] = out_ready;
    assign out_valid  = v[QUO_W];

    // zero divisor drives every quotient bit to one; force the colors to zero
    assign zero_w    = d[QUO_W].divisor == '0;
    assign out_red   = zero_w ? '0 : d[QUO_W].quo[CH_RED];
    assign out_green = zero_w ? '0 : d[QUO_W].quo[CH_GREEN];
    assign out_blue  = zero_w ? '0 : d[QUO_W].quo[CH_BLUE];
    assign out_alpha = d[QUO_W].alpha;

endmodule
